### design/kdlr_pkg.sv
// Package: shared types, program ROM and key constants for the key front end.
`default_nettype none

package kdlr_pkg;

    // Number of keys and default sizes
    localparam int NUM_KEYS       = 4;
    localparam int KEY_W          = 2;
    localparam int FIFO_DEPTH_DEF = 16;
    localparam int CODE_W         = 4;

    // Register reset values
    localparam logic [6:0]  FILTER_TIME_RST   = 7'd5;
    localparam logic [15:0] LONG_TIME_RST     = 16'd100;
    localparam logic [7:0]  REPEAT_PERIOD_RST = 8'd5;
    localparam logic [7:0]  FILTER_COUNT_RST  = 8'(FILTER_TIME_RST / 2);

    // Command codes
    localparam logic [1:0] CMD_SCAN  = 2'd0;
    localparam logic [1:0] CMD_POP   = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_FILTER_TIME   = 2'd0;
    localparam logic [1:0] REG_LONG_TIME     = 2'd1;
    localparam logic [1:0] REG_REPEAT_PERIOD = 2'd2;

    // Event offsets added to 3*k
    localparam logic [CODE_W-1:0] EV_PRESS   = 4'd1;
    localparam logic [CODE_W-1:0] EV_RELEASE = 4'd2;
    localparam logic [CODE_W-1:0] EV_LONG    = 4'd3;

    // Program steps
    typedef logic [2:0] step_t;
    localparam step_t S_IDLE  = 3'd0;
    localparam step_t S_EVAL  = 3'd1;
    localparam step_t S_PUSH1 = 3'd2;
    localparam step_t S_PUSH2 = 3'd3;
    localparam step_t S_POPW  = 3'd4;
    localparam step_t S_POPT  = 3'd5;
    localparam step_t S_CLR   = 3'd6;
    localparam step_t S_EMIT  = 3'd7;

    // Datapath operations
    typedef enum logic [2:0] {
        OP_NOP,
        OP_EVAL,
        OP_PUSH1,
        OP_PUSH2,
        OP_POP,
        OP_CLEAR,
        OP_EMIT
    } op_t;

    // Sequencing modes
    typedef enum logic [2:0] {
        JMP_NEXT,
        JMP_ALWAYS,
        JMP_DISPATCH,
        JMP_KEYLOOP,
        JMP_EMIT
    } jmp_t;

    typedef struct packed {
        op_t   op;
        jmp_t  jmp;
        step_t target;
    } uword_t;

    // Control from sequencer to datapath
    typedef struct packed {
        op_t  op;
        logic start;
    } ctrl_t;

    // Status from datapath to sequencer
    typedef struct packed {
        logic last_key;
        logic out_free;
    } stat_t;

    // Program ROM
    function automatic uword_t ucode_rom(input step_t s);
        uword_t w;
        case (s)
            S_IDLE:  w = '{op: OP_NOP,   jmp: JMP_DISPATCH, target: S_IDLE};
            S_EVAL:  w = '{op: OP_EVAL,  jmp: JMP_NEXT,     target: S_IDLE};
            S_PUSH1: w = '{op: OP_PUSH1, jmp: JMP_NEXT,     target: S_IDLE};
            S_PUSH2: w = '{op: OP_PUSH2, jmp: JMP_KEYLOOP,  target: S_EVAL};
            S_POPW:  w = '{op: OP_NOP,   jmp: JMP_NEXT,     target: S_IDLE};
            S_POPT:  w = '{op: OP_POP,   jmp: JMP_ALWAYS,   target: S_EMIT};
            S_CLR:   w = '{op: OP_CLEAR, jmp: JMP_ALWAYS,   target: S_EMIT};
            S_EMIT:  w = '{op: OP_EMIT,  jmp: JMP_EMIT,     target: S_IDLE};
            default: w = '{op: OP_NOP,   jmp: JMP_ALWAYS,   target: S_IDLE};
        endcase
        return w;
    endfunction

    // Entry point of each command's routine
    function automatic step_t dispatch_target(input logic [1:0] cmd);
        step_t s;
        case (cmd)
            CMD_SCAN:  s = S_EVAL;
            CMD_POP:   s = S_POPW;
            CMD_CLEAR: s = S_CLR;
            default:   s = S_EMIT;
        endcase
        return s;
    endfunction

    // Pin pattern that marks each key as down
    function automatic logic [3:0] key_pattern(input logic [KEY_W-1:0] k);
        logic [3:0] p;
        case (k)
            2'd0:    p = 4'b0110;
            2'd1:    p = 4'b0101;
            2'd2:    p = 4'b0011;
            default: p = 4'b1111;
        endcase
        return p;
    endfunction

    // Code base 3*k for each key
    function automatic logic [CODE_W-1:0] key_base(input logic [KEY_W-1:0] k);
        logic [CODE_W-1:0] b;
        case (k)
            2'd0:    b = 4'd0;
            2'd1:    b = 4'd3;
            2'd2:    b = 4'd6;
            default: b = 4'd9;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

### design/kdlr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module kdlr_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### design/kdlr_seq.sv
// Microcode sequencer: step counter, program ROM and jump logic.
`default_nettype none

module kdlr_seq
    import kdlr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic [1:0] cmd,
    input  wire stat_t      stat,
    output logic            in_stall,
    output ctrl_t           ctrl
);

    step_t  step_reg;
    step_t  step_next;
    uword_t uw;
    logic   in_fire;

    assign uw       = ucode_rom(step_reg);
    assign in_stall = (step_reg != S_IDLE);
    assign in_fire  = in_valid && !in_stall;

    assign ctrl.op    = uw.op;
    assign ctrl.start = in_fire;

    // Pick the next step
    always_comb
    begin
        case (uw.jmp)
            JMP_NEXT:     step_next = step_reg + step_t'(1);
            JMP_ALWAYS:   step_next = uw.target;
            JMP_DISPATCH: step_next = in_fire ? dispatch_target(cmd) : step_reg;
            JMP_KEYLOOP:  step_next = stat.last_key ? S_EMIT : uw.target;
            JMP_EMIT:     step_next = stat.out_free ? uw.target : step_reg;
            default:      step_next = S_IDLE;
        endcase
    end

    // Advance the step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == S_EMIT && !stat.out_free) |=> (step_reg == S_EMIT))
        else $error("sequencer left emit step while output was blocked");
`endif

endmodule

`default_nettype wire

### design/kdlr_dp.sv
// Datapath: config registers, per-key filter records, event ring and output register.
`default_nettype none

module kdlr_dp
    import kdlr_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire ctrl_t       ctrl,
    output stat_t            stat,
    input  wire logic [3:0]  pin_levels,
    input  wire logic        cfg_valid,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [3:0]       key_code,
    output logic [3:0]       key_states
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

    // Config registers
    logic [6:0]  filter_time_reg;
    logic [15:0] long_time_reg;
    logic [7:0]  repeat_period_reg;

    // Per-key records
    logic [7:0]  fc_reg [NUM_KEYS];
    logic [15:0] hc_reg [NUM_KEYS];
    logic [7:0]  rc_reg [NUM_KEYS];
    logic [NUM_KEYS-1:0] pressed_reg;

    logic [KEY_W-1:0]  key_idx_reg;
    logic [3:0]        pin_reg;
    logic [CODE_W-1:0] code_reg;
    logic              push1_reg;
    logic              push2_reg;
    logic [CODE_W-1:0] push1_code_reg;
    logic [CODE_W-1:0] push2_code_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic              out_valid_reg;
    logic [3:0]        key_code_reg;
    logic [3:0]        key_states_reg;

    // Evaluation results for the current key
    logic [7:0]        fc_next;
    logic [15:0]       hc_next;
    logic [7:0]        rc_next;
    logic              pr_next;
    logic              push1_next;
    logic              push2_next;
    logic [CODE_W-1:0] push1_code_next;
    logic [CODE_W-1:0] push2_code_next;

    logic [7:0]        fc_cur;
    logic [15:0]       hc_cur;
    logic [7:0]        rc_cur;
    logic              pr_cur;
    logic [7:0]        ft_ext;
    logic [7:0]        ft_twice;
    logic [15:0]       hc_inc;
    logic [7:0]        rc_inc;
    logic [CODE_W-1:0] base;
    logic              down;

    logic              ram_we;
    logic [CODE_W-1:0] ram_wdata;
    logic [CODE_W-1:0] ram_rdata;
    logic              ring_empty;
    logic              out_free;
    logic              emit_fire;

    assign fc_cur   = fc_reg[key_idx_reg];
    assign hc_cur   = hc_reg[key_idx_reg];
    assign rc_cur   = rc_reg[key_idx_reg];
    assign pr_cur   = pressed_reg[key_idx_reg];
    assign ft_ext   = {1'b0, filter_time_reg};
    assign ft_twice = {filter_time_reg, 1'b0};
    assign hc_inc   = hc_cur + 16'd1;
    assign rc_inc   = rc_cur + 8'd1;
    assign base     = key_base(key_idx_reg);
    assign down     = (pin_reg == key_pattern(key_idx_reg));

    // Filter, long-press and repeat decision for one key
    always_comb
    begin
        fc_next         = fc_cur;
        hc_next         = hc_cur;
        rc_next         = rc_cur;
        pr_next         = pr_cur;
        push1_next      = 1'b0;
        push2_next      = 1'b0;
        push1_code_next = base + EV_PRESS;
        push2_code_next = base + EV_LONG;
        if (down)
        begin
            if (fc_cur < ft_ext)
            begin
                fc_next = ft_ext;
            end
            else if (fc_cur < ft_twice)
            begin
                fc_next = fc_cur + 8'd1;
            end
            else
            begin
                if (!pr_cur)
                begin
                    pr_next    = 1'b1;
                    push1_next = 1'b1;
                end
                if (long_time_reg != 16'd0)
                begin
                    if (hc_cur < long_time_reg)
                    begin
                        hc_next    = hc_inc;
                        push2_next = (hc_inc == long_time_reg);
                    end
                    else if (repeat_period_reg != 8'd0)
                    begin
                        rc_next = rc_inc;
                        if (rc_inc >= repeat_period_reg)
                        begin
                            rc_next         = 8'd0;
                            push2_next      = 1'b1;
                            push2_code_next = base + EV_PRESS;
                        end
                    end
                end
            end
        end
        else
        begin
            push1_code_next = base + EV_RELEASE;
            if (fc_cur > ft_ext)
            begin
                fc_next = ft_ext;
            end
            else if (fc_cur != 8'd0)
            begin
                fc_next = fc_cur - 8'd1;
            end
            else if (pr_cur)
            begin
                pr_next    = 1'b0;
                push1_next = 1'b1;
            end
            hc_next = 16'd0;
            rc_next = 8'd0;
        end
    end

    // Ring write and read control
    assign ram_we     = (ctrl.op == OP_PUSH1 && push1_reg) || (ctrl.op == OP_PUSH2 && push2_reg);
    assign ram_wdata  = (ctrl.op == OP_PUSH1) ? push1_code_reg : push2_code_reg;
    assign ring_empty = (rd_ptr_reg == wr_ptr_reg);

    kdlr_ram #(
        .WIDTH (CODE_W),
        .DEPTH (FIFO_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_ptr_reg),
        .wdata (ram_wdata),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    assign out_free  = !out_valid_reg || !out_stall;
    assign emit_fire = (ctrl.op == OP_EMIT) && out_free;

    assign stat.last_key = (key_idx_reg == KEY_W'(NUM_KEYS - 1));
    assign stat.out_free = out_free;

    assign out_valid  = out_valid_reg;
    assign key_code   = key_code_reg;
    assign key_states = key_states_reg;

    // Config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_time_reg   <= FILTER_TIME_RST;
            long_time_reg     <= LONG_TIME_RST;
            repeat_period_reg <= REPEAT_PERIOD_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_FILTER_TIME:   filter_time_reg   <= cfg_data[6:0];
                REG_LONG_TIME:     long_time_reg     <= cfg_data;
                REG_REPEAT_PERIOD: repeat_period_reg <= cfg_data[7:0];
                default:           ;
            endcase
        end
    end

    // Update key records on evaluation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_KEYS; i++)
            begin
                fc_reg[i] <= FILTER_COUNT_RST;
                hc_reg[i] <= 16'd0;
                rc_reg[i] <= 8'd0;
            end
            pressed_reg <= '0;
        end
        else if (ctrl.op == OP_EVAL)
        begin
            fc_reg[key_idx_reg]      <= fc_next;
            hc_reg[key_idx_reg]      <= hc_next;
            rc_reg[key_idx_reg]      <= rc_next;
            pressed_reg[key_idx_reg] <= pr_next;
        end
    end

    // Key index, pending push flags and ring pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_idx_reg <= '0;
            push1_reg   <= 1'b0;
            push2_reg   <= 1'b0;
            rd_ptr_reg  <= '0;
            wr_ptr_reg  <= '0;
        end
        else
        begin
            if (ctrl.start)
            begin
                key_idx_reg <= '0;
            end
            else if (ctrl.op == OP_PUSH2)
            begin
                key_idx_reg <= key_idx_reg + KEY_W'(1);
            end
            if (ctrl.op == OP_EVAL)
            begin
                push1_reg <= push1_next;
                push2_reg <= push2_next;
            end
            if (ram_we)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (ctrl.op == OP_POP && !ring_empty)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            else if (ctrl.op == OP_CLEAR)
            begin
                rd_ptr_reg <= wr_ptr_reg;
            end
        end
    end

    // Payload holding registers
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            pin_reg  <= pin_levels;
            code_reg <= '0;
        end
        else if (ctrl.op == OP_POP && !ring_empty)
        begin
            code_reg <= ram_rdata;
        end
        if (ctrl.op == OP_EVAL)
        begin
            push1_code_reg <= push1_code_next;
            push2_code_reg <= push2_code_next;
        end
        if (emit_fire)
        begin
            key_code_reg   <= code_reg;
            key_states_reg <= pressed_reg;
        end
    end

    // Output valid: set on emit, drop when the beat is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

`ifndef NO_ASSERTIONS
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == OP_CLEAR) |=> (rd_ptr_reg == wr_ptr_reg))
        else $error("ring not empty after clear");

    a_write_in_push: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (ctrl.op == OP_PUSH1 || ctrl.op == OP_PUSH2))
        else $error("ring written outside a push step");

    a_pressed_only_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op != OP_EVAL) |=> $stable(pressed_reg))
        else $error("pressed flags changed outside evaluation");
`endif

endmodule

`default_nettype wire

### design/key_debounce_long_repeat_fifo_top.sv
// Top level: four-key debounce front end with long press, auto-repeat and event ring.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_stall    cmd, pin_levels
//   out      source     out_valid / out_stall  key_code, key_states
//   cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A scan beat runs accept, then three program steps per key
// (evaluate, first push, second push) for four keys, then emit.
// A pop beat runs accept, ring read wait, take, emit; clear runs accept, clear, emit.
// The sequence follows from the key-at-a-time program and the single ring write port.
// A stalled output holds the emit step; the next beat is accepted once it is posted.
// Reset is asynchronous; no clearing pass is needed, cfg_ready is always high.
`default_nettype none

module key_debounce_long_repeat_fifo_top
    import kdlr_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  cmd,
    input  wire logic [3:0]  pin_levels,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [3:0]       key_code,
    output logic [3:0]       key_states,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    ctrl_t ctrl;
    stat_t stat;

    assign cfg_ready = 1'b1;

    kdlr_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .cmd      (cmd),
        .stat     (stat),
        .in_stall (in_stall),
        .ctrl     (ctrl)
    );

    kdlr_dp #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .stat       (stat),
        .pin_levels (pin_levels),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .key_code   (key_code),
        .key_states (key_states)
    );

endmodule

`default_nettype wire

### bench/key_debounce_long_repeat_fifo_top_test.sv
// Self-checking bench for the four-key debounce front end with long press, repeat and event ring.
`timescale 1ns / 1ps

module key_debounce_long_repeat_fifo_top_test
    import kdlr_pkg::*;
;

    localparam int RING_DEPTH = FIFO_DEPTH_DEF;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    // Pin pattern that holds each key down, pin one in bit 0
    localparam logic [3:0] KEY_DOWN_PINS [NUM_KEYS] = '{4'd6, 4'd5, 4'd3, 4'd15};

    typedef struct packed {
        logic [3:0] code;
        logic [3:0] states;
    } key_report_t;

    // Mirror of the key records and event ring; holds the reports still owed by the block
    class key_event_tracker;
        logic [6:0]  filter_time;
        logic [15:0] long_time;
        logic [7:0]  repeat_period;
        logic [7:0]  flt_cnt [NUM_KEYS];
        bit          held [NUM_KEYS];
        logic [15:0] hold_cnt [NUM_KEYS];
        logic [7:0]  rep_cnt [NUM_KEYS];
        logic [CODE_W-1:0] ring [RING_DEPTH];
        logic [3:0]  rd_ptr;
        logic [3:0]  wr_ptr;
        key_report_t awaited [$];
        int          errors;

        function new();
            filter_time   = FILTER_TIME_RST;
            long_time     = LONG_TIME_RST;
            repeat_period = REPEAT_PERIOD_RST;
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                flt_cnt[k]  = FILTER_COUNT_RST;
                held[k]     = 1'b0;
                hold_cnt[k] = '0;
                rep_cnt[k]  = '0;
            end
            rd_ptr = '0;
            wr_ptr = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] data);
            case (idx)
                REG_FILTER_TIME:   filter_time   = data[6:0];
                REG_LONG_TIME:     long_time     = data;
                REG_REPEAT_PERIOD: repeat_period = data[7:0];
                default: ;
            endcase
        endfunction

        // Push without a full check: the write pointer always advances
        function void push(logic [CODE_W-1:0] code);
            ring[wr_ptr] = code;
            wr_ptr = wr_ptr + 4'd1;
        endfunction

        function logic [CODE_W-1:0] pop();
            logic [CODE_W-1:0] code;
            if (rd_ptr == wr_ptr)
                return '0;
            code   = ring[rd_ptr];
            rd_ptr = rd_ptr + 4'd1;
            return code;
        endfunction

        // Advance one key's hysteresis counter, hold and repeat timers
        function void filter_one(int k, bit down);
            logic [CODE_W-1:0] base;
            base = CODE_W'(3 * k);
            if (down)
            begin
                if (flt_cnt[k] < 8'(filter_time))
                    flt_cnt[k] = 8'(filter_time);
                else if (flt_cnt[k] < {filter_time, 1'b0})
                    flt_cnt[k] = flt_cnt[k] + 8'd1;
                else
                begin
                    if (!held[k])
                    begin
                        held[k] = 1'b1;
                        push(base + EV_PRESS);
                    end
                    if (long_time != '0)
                    begin
                        if (hold_cnt[k] < long_time)
                        begin
                            hold_cnt[k] = hold_cnt[k] + 16'd1;
                            if (hold_cnt[k] == long_time)
                                push(base + EV_LONG);
                        end
                        else if (repeat_period != '0)
                        begin
                            rep_cnt[k] = rep_cnt[k] + 8'd1;
                            if (rep_cnt[k] >= repeat_period)
                            begin
                                rep_cnt[k] = '0;
                                push(base + EV_PRESS);
                            end
                        end
                    end
                end
            end
            else
            begin
                if (flt_cnt[k] > 8'(filter_time))
                    flt_cnt[k] = 8'(filter_time);
                else if (flt_cnt[k] != '0)
                    flt_cnt[k] = flt_cnt[k] - 8'd1;
                else if (held[k])
                begin
                    held[k] = 1'b0;
                    push(base + EV_RELEASE);
                end
                hold_cnt[k] = '0;
                rep_cnt[k]  = '0;
            end
        endfunction

        // Apply one accepted command and queue the report it owes
        function void take_command(logic [1:0] cmd, logic [3:0] pins);
            key_report_t r;
            r.code = '0;
            case (cmd)
                CMD_SCAN:
                    for (int k = 0; k < NUM_KEYS; k++)
                        filter_one(k, pins == KEY_DOWN_PINS[k]);
                CMD_POP:   r.code = pop();
                CMD_CLEAR: rd_ptr = wr_ptr;
                default: ;
            endcase
            for (int k = 0; k < NUM_KEYS; k++)
                r.states[k] = held[k];
            awaited.push_back(r);
        endfunction

        function void match_report(logic [3:0] code, logic [3:0] states);
            key_report_t r;
            if (awaited.size() == 0)
            begin
                $display("%0t: report with none owed: key_code %0d key_states %b",
                         $time, code, states);
                errors++;
                return;
            end
            r = awaited.pop_front();
            if (code !== r.code)
            begin
                $display("%0t: key_code mismatch: expected %0d, actual %0d",
                         $time, r.code, code);
                errors++;
            end
            if (states !== r.states)
            begin
                $display("%0t: key_states mismatch: expected %b, actual %b",
                         $time, r.states, states);
                errors++;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic [1:0]  cmd        = CMD_SCAN;
    logic [3:0]  pin_levels = 4'd0;
    logic        out_valid;
    logic        out_stall  = 1'b0;
    logic [3:0]  key_code;
    logic [3:0]  key_states;
    logic        cfg_valid  = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index  = REG_FILTER_TIME;
    logic [15:0] cfg_data   = 16'd0;

    key_event_tracker tracker;
    int items_sent = 0;
    int gap_pct    = 0;
    int stall_pct  = 0;
    int stall_left = 0;
    bit quiet      = 1'b0;

    key_debounce_long_repeat_fifo_top #(
        .FIFO_DEPTH (RING_DEPTH)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .pin_levels (pin_levels),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .key_code   (key_code),
        .key_states (key_states),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("key_debounce_long_repeat_fifo_top test failed");
        $finish;
    end

    // Stall the report side in random bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (!quiet && rst_n && $urandom_range(0, 99) < stall_pct)
        begin
            stall_left = $urandom_range(0, 18);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Check every report beat
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.match_report(key_code, key_states);
    end

    // Offer one command beat, with an optional idle burst ahead of it
    task automatic send_item(input logic [1:0] c, input logic [3:0] p);
        int gap;
        if (!quiet && $urandom_range(0, 99) < gap_pct)
        begin
            gap = $urandom_range(1, 19);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        cmd        <= c;
        pin_levels <= p;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        tracker.take_command(c, p);
        items_sent++;
    endtask

    // Write the three registers back to back, optionally poking the unused index too
    task automatic program_regs(input int ft, input int lt, input int rp, input bit poke);
        logic [1:0]  order [4];
        logic [15:0] d;
        int          last;
        order = '{REG_FILTER_TIME, REG_LONG_TIME, REG_REPEAT_PERIOD, REG_UNUSED};
        last  = poke ? 3 : 2;
        for (int i = 0; i <= last; i++)
        begin
            d = 16'($urandom);
            case (order[i])
                REG_FILTER_TIME:   d[6:0] = 7'(ft);
                REG_LONG_TIME:     d      = 16'(lt);
                REG_REPEAT_PERIOD: d[7:0] = 8'(rp);
                default: ;
            endcase
            cfg_valid <= 1'b1;
            cfg_index <= order[i];
            cfg_data  <= d;
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
            tracker.write_reg(order[i], d);
        end
        cfg_valid <= 1'b0;
    endtask

    // Random mix: mostly key holds long enough to press, hold and repeat, plus noise
    task automatic run_random(input int budget);
        int         start;
        int         pick;
        int         len;
        int         span;
        int         k;
        logic [3:0] p;
        logic [6:0] ft;
        logic [15:0] lt;
        logic [7:0] rp;
        ft    = tracker.filter_time;
        lt    = tracker.long_time;
        rp    = tracker.repeat_period;
        start = items_sent;
        while (items_sent - start < budget)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
            begin
                // hold one key down, popping now and then
                k    = $urandom_range(0, NUM_KEYS - 1);
                span = 2 * ft + 2;
                if (lt != 0 && lt < 200)
                    span += lt + 3 * rp + 2;
                if (span > 300)
                    span = 300;
                len = $urandom_range(1, span);
                if (len > budget - (items_sent - start))
                    len = budget - (items_sent - start);
                repeat (len)
                begin
                    send_item(CMD_SCAN, KEY_DOWN_PINS[k]);
                    if ($urandom_range(0, 99) < 15)
                        send_item(CMD_POP, 4'($urandom));
                end
            end
            else if (pick < 68)
            begin
                // let go with levels that match no key
                len = $urandom_range(1, 2 * ft + 3);
                if (len > budget - (items_sent - start))
                    len = budget - (items_sent - start);
                repeat (len)
                begin
                    p = 4'($urandom);
                    if (p == KEY_DOWN_PINS[0] || p == KEY_DOWN_PINS[1] ||
                        p == KEY_DOWN_PINS[2] || p == KEY_DOWN_PINS[3])
                        p = 4'd0;
                    send_item(CMD_SCAN, p);
                end
            end
            else if (pick < 85)
                repeat ($urandom_range(1, 8)) send_item(CMD_POP, 4'($urandom));
            else if (pick < 90)
                send_item(CMD_CLEAR, 4'($urandom));
            else if (pick < 94)
                send_item(CMD_UNUSED, 4'($urandom));
            else
                send_item(CMD_SCAN, 4'($urandom));
        end
    endtask

    // Drain, reprogram, then run a random stretch
    task automatic run_phase(input int ft, input int lt, input int rp, input bit poke,
                             input int budget, input int gap, input int stall);
        while (tracker.pending() != 0) @(posedge clk);
        program_regs(ft, lt, rp, poke);
        gap_pct   = gap;
        stall_pct = stall;
        run_random(budget);
        in_valid <= 1'b0;
    endtask

    initial
    begin
        tracker = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats on reset settings: empty pop, unused command, clear,
        // one-tick glitches on three keys, a full press and release of key 3
        gap_pct   = 20;
        stall_pct = 8;
        send_item(CMD_POP, 4'd0);
        send_item(CMD_UNUSED, 4'd15);
        send_item(CMD_CLEAR, 4'd0);
        send_item(CMD_SCAN, KEY_DOWN_PINS[0]);
        send_item(CMD_SCAN, KEY_DOWN_PINS[1]);
        send_item(CMD_SCAN, KEY_DOWN_PINS[2]);
        repeat (8) send_item(CMD_SCAN, KEY_DOWN_PINS[3]);
        repeat (3) send_item(CMD_POP, 4'd0);
        repeat (7) send_item(CMD_SCAN, 4'd0);
        repeat (2) send_item(CMD_POP, 4'd15);
        in_valid <= 1'b0;

        run_phase(1, 3, 1, 1'b0, 60, 30, 8);
        run_phase(0, 0, 0, 1'b1, 50, 0, 0);
        run_phase(127, 65535, 255, 1'b1, 150, 10, 3);
        run_phase(2, 10, 3, 1'b0, 60, 40, 15);
        run_phase(3, 1, 0, 1'b0, 60, 20, 8);
        repeat (3)
        begin
            run_phase($urandom_range(0, 8),
                      $urandom_range(0, 1) ? $urandom_range(0, 20) : $urandom_range(0, 65535),
                      $urandom_range(0, 6), 1'b0, 50, 20, 8);
        end
        quiet = 1'b1;
        run_phase(1, 2, 2, 1'b0, 50, 0, 0);

        while (tracker.pending() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (tracker.errors == 0)
            $display("key_debounce_long_repeat_fifo_top test passed");
        else
            $display("key_debounce_long_repeat_fifo_top test failed");
        $finish;
    end

endmodule

### files.f
design/kdlr_pkg.sv
design/kdlr_ram.sv
design/kdlr_seq.sv
design/kdlr_dp.sv
design/key_debounce_long_repeat_fifo_top.sv
bench/key_debounce_long_repeat_fifo_top_test.sv
